// ----- hw/rtl/pcdd_pkg.sv -----
// Shared types and constants for the PI tilt controller with dead zone.
`default_nettype none

package pcdd_pkg;

    // Field widths
    localparam int POS_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int MAG_W   = 16;
    localparam int FRAC_W  = 24;
    localparam int ACC_W   = MAG_W + FRAC_W;   // Q16.24 terms
    localparam int CFG_W   = 24;
    localparam int ADDR_W  = 3;
    localparam int OUT_W   = 40;               // 34 bits of fields, padded to bytes

    // Queue between classifier and PI datapath
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Reset values of the configuration registers
    localparam logic signed [POS_W-1:0] TARGET_RST = '0;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd503316;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd2768;
    localparam logic [MAG_W-1:0]  DEAD_ZONE_RST  = 16'd100;
    localparam logic [MAG_W-1:0]  LIMIT_RST      = 16'd65535;

    // Register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_TARGET     = 3'd0,
        REG_PROP_GAIN  = 3'd1,
        REG_INTEG_GAIN = 3'd2,
        REG_DEAD_ZONE  = 3'd3,
        REG_LIMIT      = 3'd4
    } reg_idx_t;

    // Configuration register set
    typedef struct packed {
        logic signed [POS_W-1:0] target_position;
        logic [GAIN_W-1:0]       prop_gain;
        logic [GAIN_W-1:0]       integ_gain;
        logic [MAG_W-1:0]        dead_zone;
        logic [MAG_W-1:0]        drive_limit;
    } cfg_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0] error_size;
        logic             reverse;
        logic             inside_dead_zone;
    } item_t;

endpackage : pcdd_pkg

`default_nettype wire

// ----- hw/rtl/pi_controller_deadband_direction_top.sv -----
// Top level of the PI tilt controller with dead zone and direction output.
//
// Input stream s_*: one signed 16-bit axis sample per transfer in s_tdata.
// Output stream m_*: one result per sample, m_tdata holds from bit 0 up:
// drive_level[15:0], reverse[16], error_size[32:17], inside_dead_zone[33],
// zeros in [39:34].
// Config port: cfg_we writes cfg_data into register cfg_addr (0 target,
// 1 proportional gain, 2 integral gain, 3 dead zone, 4 drive limit); other
// indexes are ignored. Write only while no samples are in flight.
// Throughput: one sample per cycle while m_tready is high. Path from input
// transfer to m_tvalid: classifier register, queue, product stage,
// integral stage, output register. The integral add-and-clamp loop is a
// single register fed back through the clamp, which sets that rate.
// A 4-entry queue between classifier and datapath lets the input take samples
// after m_tready drops until queue and classifier fill; then s_tready falls.
// Reset clears the integral, all valid flags and loads the default gains.
`default_nettype none

module pi_controller_deadband_direction_top
    import pcdd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // sample stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [POS_W-1:0]  s_tdata,   // [15:0] measured_position
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // drive_level, reverse, error_size, inside_dead_zone
    // configuration writes
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_position <= TARGET_RST;
            cfg_reg.prop_gain       <= PROP_GAIN_RST;
            cfg_reg.integ_gain      <= INTEG_GAIN_RST;
            cfg_reg.dead_zone       <= DEAD_ZONE_RST;
            cfg_reg.drive_limit     <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET:     cfg_reg.target_position <= cfg_data[POS_W-1:0];
                REG_PROP_GAIN:  cfg_reg.prop_gain       <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: cfg_reg.integ_gain      <= cfg_data[GAIN_W-1:0];
                REG_DEAD_ZONE:  cfg_reg.dead_zone       <= cfg_data[MAG_W-1:0];
                REG_LIMIT:      cfg_reg.drive_limit     <= cfg_data[MAG_W-1:0];
                default:        ;
            endcase
        end
    end

    pcdd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    pcdd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    pcdd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Inside the dead zone the drive must be zero
    a_dead_zone_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[15:0] == 16'd0)
        else $error("drive nonzero inside dead zone");

    // Zero error never reports reverse direction
    a_zero_err_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32:17] == 16'd0 |-> !m_tdata[16])
        else $error("reverse set with zero error");

    // Padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:34] == 6'd0)
        else $error("padding bits set");

endmodule : pi_controller_deadband_direction_top

`default_nettype wire

// ----- hw/rtl/pcdd_front.sv -----
// Front end: takes samples, forms the exact error, direction and dead-zone flag.
`default_nettype none

module pcdd_front
    import pcdd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [POS_W-1:0] s_tdata,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output item_t                 out_item
);

    logic             valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [POS_W:0]   err;
    logic [POS_W:0]   mag17;

    // Exact 17-bit error, sign and magnitude
    always_comb
    begin
        err   = {cfg.target_position[POS_W-1], cfg.target_position}
              - {s_tdata[POS_W-1], s_tdata};
        mag17 = err[POS_W] ? (~err + 1'b1) : err;
        item_next.reverse          = err[POS_W];
        item_next.error_size       = mag17[MAG_W-1:0];
        item_next.inside_dead_zone = (mag17[MAG_W-1:0] < cfg.dead_zone);
    end

    assign s_tready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

endmodule : pcdd_front

`default_nettype wire

// ----- hw/rtl/pcdd_queue.sv -----
// Short flop queue decoupling the classifier from the PI datapath.
`default_nettype none

module pcdd_queue
    import pcdd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_item
);

    item_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule : pcdd_queue

`default_nettype wire

// ----- hw/rtl/pcdd_back.sv -----
// Back end: gain products, saturating integral, drive sum and output register.
`default_nettype none

module pcdd_back
    import pcdd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic              adv;
    // stage 1: products
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [ACC_W-1:0]  s1_p_reg;
    logic [ACC_W-1:0]  s1_i_reg;
    // stage 2: integral updated, P carried
    logic              s2_valid_reg;
    item_t             s2_item_reg;
    logic [ACC_W-1:0]  s2_p_reg;
    // integral state
    logic [ACC_W-1:0]  integral_reg;
    logic [ACC_W-1:0]  integral_next;
    // output
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    logic [ACC_W:0]    i_sum;
    logic [ACC_W:0]    lim_fx;
    logic [ACC_W:0]    d_sum;
    logic [MAG_W:0]    d_int;
    logic [MAG_W-1:0]  drive;

    // Whole pipeline moves when the output slot is free or being taken
    assign adv      = !out_valid_reg || m_tready;
    assign in_ready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Saturating integral update
    always_comb
    begin
        lim_fx = {1'b0, cfg.drive_limit, {FRAC_W{1'b0}}};
        i_sum  = {1'b0, integral_reg} + {1'b0, s1_i_reg};
        if (i_sum > lim_fx)
        begin
            integral_next = lim_fx[ACC_W-1:0];
        end
        else
        begin
            integral_next = i_sum[ACC_W-1:0];
        end
    end

    // Drive: integer part of P + I, clamped to the limit, zero in dead zone
    always_comb
    begin
        d_sum = {1'b0, s2_p_reg} + {1'b0, integral_reg};
        d_int = d_sum[ACC_W:FRAC_W];
        if (s2_item_reg.inside_dead_zone)
        begin
            drive = '0;
        end
        else if (d_int > {1'b0, cfg.drive_limit})
        begin
            drive = cfg.drive_limit;
        end
        else
        begin
            drive = d_int[MAG_W-1:0];
        end
        out_data_next = {6'd0, s2_item_reg.inside_dead_zone, s2_item_reg.error_size,
                         s2_item_reg.reverse, drive};
    end

    // Valid bits and integral state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg && !s1_item_reg.inside_dead_zone)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg  <= in_item;
            s1_p_reg     <= ACC_W'(in_item.error_size) * ACC_W'(cfg.prop_gain);
            s1_i_reg     <= ACC_W'(in_item.error_size) * ACC_W'(cfg.integ_gain);
            s2_item_reg  <= s1_item_reg;
            s2_p_reg     <= s1_p_reg;
            out_data_reg <= out_data_next;
        end
    end

endmodule : pcdd_back

`default_nettype wire
